// File: hdl/pdts_pkg.sv
// shared types, constants and elaboration-time tables for the decaying tone synth
// no dependencies; imported by every other file in this folder
package pdts_pkg;

    localparam int VOICES           = 13;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_BITS       = 32;

    localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SIDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int QIDX_W  = SIDX_W - 1;
    localparam int LEVEL_W = 31;
    localparam int DECAY_W = 16;
    localparam int MAG_W   = 16;
    localparam int TERM_W  = 33;
    localparam int ACC_W   = TERM_W + ((VOICES > 1) ? $clog2(VOICES) : 0);
    localparam int NOTE_W  = 4;
    localparam int SAMPLE_W = 32;

    localparam logic [LEVEL_W-1:0] PEAK_RESET  = 31'd165191049;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd65529;

    // register map, indexed by paddr[2]
    localparam int  ADDR_W    = 3;
    localparam logic REG_PEAK  = 1'b0;
    localparam logic REG_DECAY = 1'b1;

    // input transaction kinds
    typedef enum logic {OP_TICK = 1'b0, OP_KEY = 1'b1} op_t;

    localparam logic [63:0] QA1 = 64'd102944;
    localparam logic [63:0] QA3 = 64'd42048;
    localparam logic [63:0] QA5 = 64'd4640;

    localparam logic [31:0] SEMI_INC [12] = '{
        32'd23409859, 32'd24801882, 32'd26276679, 32'd27839171,
        32'd29494575, 32'd31248413, 32'd33106541, 32'd35075158,
        32'd37160835, 32'd39370534, 32'd41711627, 32'd44191930
    };

    typedef struct packed {
        logic [LEVEL_W-1:0] peak_level;
        logic [DECAY_W-1:0] decay_factor;
    } cfg_t;

    typedef struct packed {
        logic              key_wr;
        logic              acc_clr;
        logic              step;
        logic [VIDX_W-1:0] voice;
        logic              out_load;
    } cmd_t;

    typedef logic [MAG_W-1:0]      qsine_tab_t [QUARTER+1];
    typedef logic [PHASE_BITS-1:0] inc_tab_t   [VOICES];

    // quarter-wave magnitude table, q15, indexed by distance into the quadrant
    function automatic qsine_tab_t build_qsine();
        qsine_tab_t  tab;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] r;
        logic [63:0] s;
        for (int i = 0; i <= QUARTER; i++)
        begin
            u  = (64'(i) * 64'd65536) / 64'(QUARTER);
            u2 = (u * u) >> 16;
            r  = QA3 - ((u2 * QA5) >> 16);
            r  = QA1 - ((u2 * r) >> 16);
            s  = (u * r) >> 16;
            tab[i] = MAG_W'((s * 64'd32767 + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    // per-voice phase increment: semitone within the octave, shifted up per octave
    function automatic inc_tab_t build_inc();
        inc_tab_t    tab;
        logic [63:0] inc;
        for (int v = 0; v < VOICES; v++)
        begin
            inc = {32'd0, SEMI_INC[v % 12]} << (v / 12);
            inc = inc >> (32 - PHASE_BITS);
            tab[v] = PHASE_BITS'(inc);
        end
        return tab;
    endfunction

endpackage

// File: hdl/pdts_regs.sv
// apb-style configuration registers: peak level and decay factor
// depends on pdts_pkg
module pdts_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdts_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output pdts_pkg::cfg_t               cfg
);
    import pdts_pkg::*;

    logic [LEVEL_W-1:0] peak_reg;
    logic [DECAY_W-1:0] decay_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= PEAK_RESET;
            decay_reg <= DECAY_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_PEAK:  peak_reg  <= pwdata[LEVEL_W-1:0];
                REG_DECAY: decay_reg <= pwdata[DECAY_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PEAK:  prdata = {{(32-LEVEL_W){1'b0}}, peak_reg};
            REG_DECAY: prdata = {{(32-DECAY_W){1'b0}}, decay_reg};
        endcase
    end

    assign cfg.peak_level   = peak_reg;
    assign cfg.decay_factor = decay_reg;

endmodule

// File: hdl/pdts_dp.sv
// datapath: voice level and phase registers, sine rom, term multiplier, accumulator
// depends on pdts_pkg; driven by commands from pdts_ctrl
module pdts_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pdts_pkg::cfg_t                    cfg,
    input  pdts_pkg::cmd_t                    cmd,
    input  logic [pdts_pkg::NOTE_W-1:0]       note_index,
    output logic signed [pdts_pkg::SAMPLE_W-1:0] sample_out
);
    import pdts_pkg::*;

    localparam qsine_tab_t QSINE   = build_qsine();
    localparam inc_tab_t   INC_ROM = build_inc();

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);

    logic [LEVEL_W-1:0]    level_reg [VOICES];
    logic [PHASE_BITS-1:0] phase_reg [VOICES];

    logic [LEVEL_W-1:0]    cur_level;
    logic [PHASE_BITS-1:0] cur_phase;
    logic [LEVEL_W+DECAY_W-1:0] decay_prod;
    logic [LEVEL_W-1:0]    level_next;
    logic [PHASE_BITS-1:0] phase_next;
    logic [SIDX_W-1:0]     sidx;
    logic [1:0]            quad;
    logic [QIDX_W-1:0]     qidx;
    logic                  note_ok;
    logic [VIDX_W-1:0]     note_idx;

    logic [MAG_W-1:0]      mag_s1_reg;
    logic                  neg_s1_reg;
    logic [LEVEL_W-1:0]    lvl_s1_reg;
    logic                  s1_vld_reg;

    logic [LEVEL_W+MAG_W-1:0] term_prod;
    logic [TERM_W-1:0]     term_mag;
    logic signed [TERM_W-1:0] term_next;
    logic signed [TERM_W-1:0] term_s2_reg;
    logic                  s2_vld_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SAMPLE_W-1:0] sat_next;
    logic signed [SAMPLE_W-1:0] sample_reg;

    assign cur_level  = level_reg[cmd.voice];
    assign cur_phase  = phase_reg[cmd.voice];
    assign decay_prod = cur_level * cfg.decay_factor;
    assign level_next = decay_prod[LEVEL_W+DECAY_W-1:DECAY_W];
    assign phase_next = cur_phase + INC_ROM[cmd.voice];

    assign sidx = cur_phase[PHASE_BITS-1 -: SIDX_W];
    assign quad = sidx[SIDX_W-1 -: 2];
    assign qidx = quad[0] ? (QIDX_W'(QUARTER) - {1'b0, sidx[SIDX_W-3:0]})
                          : {1'b0, sidx[SIDX_W-3:0]};

    assign note_ok  = {{(32-NOTE_W){1'b0}}, note_index} < 32'(VOICES);
    assign note_idx = VIDX_W'(note_index);

    // voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                level_reg[v] <= '0;
                phase_reg[v] <= '0;
            end
        end
        else if (cmd.key_wr && note_ok)
        begin
            level_reg[note_idx] <= cfg.peak_level;
        end
        else if (cmd.step)
        begin
            level_reg[cmd.voice] <= level_next;
            phase_reg[cmd.voice] <= phase_next;
        end
    end

    // sine rom read and level capture
    always_ff @(posedge clk)
    begin
        mag_s1_reg <= QSINE[qidx];
        neg_s1_reg <= quad[1];
        lvl_s1_reg <= cur_level;
    end

    assign term_prod = lvl_s1_reg * mag_s1_reg;
    assign term_mag  = TERM_W'(term_prod >> 15);
    assign term_next = neg_s1_reg ? -$signed(term_mag) : $signed(term_mag);

    always_ff @(posedge clk)
    begin
        term_s2_reg <= term_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.step;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(term_s2_reg);
        end
    end

    // saturate to the signed sample range
    always_comb
    begin
        priority if (acc_reg > SAT_MAX)
            sat_next = SAMPLE_W'(SAT_MAX);
        else if (acc_reg < SAT_MIN)
            sat_next = SAMPLE_W'(SAT_MIN);
        else
            sat_next = SAMPLE_W'(acc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sample_reg <= sat_next;
        end
    end

    assign sample_out = sample_reg;

endmodule

// File: hdl/pdts_ctrl.sv
// controller: input and output handshakes, voice sequencing, pipeline drain
// depends on pdts_pkg; issues commands to pdts_dp
module pdts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           op,
    output logic           out_valid,
    input  logic           out_ready,
    output pdts_pkg::cmd_t cmd
);
    import pdts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [VIDX_W-1:0] voice_reg;
    logic              drain_reg;
    logic              out_valid_reg;
    logic              accept;
    logic              out_load;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            voice_reg     <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    voice_reg <= '0;
                    if (accept && (op == OP_TICK))
                        state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (voice_reg == VIDX_W'(VOICES - 1))
                    begin
                        drain_reg <= 1'b0;
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        voice_reg <= voice_reg + VIDX_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= 1'b1;
                    if (drain_reg)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cmd.key_wr   = accept && (op == OP_KEY);
    assign cmd.acc_clr  = accept && (op == OP_TICK);
    assign cmd.step     = (state_reg == ST_RUN);
    assign cmd.voice    = voice_reg;
    assign cmd.out_load = out_load;

    assign out_valid = out_valid_reg;

endmodule

// File: hdl/polyphonic_decay_tone_synth.sv
// top level of the thirteen-voice decaying sine synthesiser
// depends on pdts_pkg, pdts_regs, pdts_ctrl and pdts_dp
//
// input channel (in_valid/in_ready, op, note_index): op 1 strikes a key and sets
// that voice to the peak level, notes above the last voice are ignored; op 0 is a
// sample tick. a key transaction produces no sample.
// a tick walks the voices one per cycle through a shared sine rom and multiplier,
// so it occupies the block through the accept, a step for each voice, a pipeline
// drain of the rom and term registers and the output load.
// in_ready is low from the accepting edge until the output load; out_valid rises
// and in_ready returns high together, at the output load.
// output channel (out_valid/out_ready, sample_out): one saturated signed sample per
// tick, held in an output register. a stalled receiver does not stop the next item
// being accepted; a second sample waits in the done state until the register frees.
// apb port: peak_level at 0x0, decay_factor at 0x4, pready tied high.
// reset silences all voices, zeroes all phases and loads the default peak level
// and decay factor; nothing is pending after reset.
module polyphonic_decay_tone_synth (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pdts_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic [pdts_pkg::NOTE_W-1:0]          note_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [pdts_pkg::SAMPLE_W-1:0] sample_out
);
    import pdts_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    pdts_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    pdts_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .note_index (note_index),
        .sample_out (sample_out)
    );

    // a tick transaction blocks further input
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !op) |=> !in_ready)
        else $error("input accepted during a tick");

    // a key transaction leaves the input ready in the following cycle
    a_key_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op) |=> in_ready)
        else $error("key transaction did not return to idle");

    // a new sample only appears once the sequencer has finished a tick
    a_out_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("sample presented without a completed tick");

endmodule

// File: bench/polyphonic_decay_tone_synth_tb.sv
// self-checking bench for the thirteen-voice decaying sine synthesiser
// depends on pdts_pkg and polyphonic_decay_tone_synth; key and tick transactions are
// predicted in the bench and every sample is compared with its expectation
`timescale 1ns / 1ps

module polyphonic_decay_tone_synth_tb;
    import pdts_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [ADDR_W-1:0] PEAK_ADDR  = {REG_PEAK, 2'b00};
    localparam logic [ADDR_W-1:0] DECAY_ADDR = {REG_DECAY, 2'b00};

    localparam longint unsigned PITCH_STEP [12] = '{
        64'd23409859, 64'd24801882, 64'd26276679, 64'd27839171,
        64'd29494575, 64'd31248413, 64'd33106541, 64'd35075158,
        64'd37160835, 64'd39370534, 64'd41711627, 64'd44191930
    };

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic                       op;
    logic [NOTE_W-1:0]          note_index;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    logic [LEVEL_W-1:0]    peak_now;
    logic [DECAY_W-1:0]    decay_now;
    logic [LEVEL_W-1:0]    level_now [VOICES];
    logic [PHASE_BITS-1:0] phase_now [VOICES];

    logic signed [SAMPLE_W-1:0] samples_due [$];
    int fail_count;
    int sent_count;
    int sample_count;
    int saturated_count;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    polyphonic_decay_tone_synth dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .note_index (note_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // q15 sine magnitude of a phase, sign returned separately
    function automatic longint unsigned sine_q15(input logic [PHASE_BITS-1:0] ph,
                                                 output logic neg);
        longint unsigned k4;
        longint unsigned quad;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned poly;
        longint unsigned s;
        k4   = ((longint'(ph) * SINE_TABLE_DEPTH) >> PHASE_BITS) * 4;
        quad = k4 / SINE_TABLE_DEPTH;
        u    = ((k4 % SINE_TABLE_DEPTH) * 65536) / SINE_TABLE_DEPTH;
        if (quad[0])
            u = 65536 - u;
        neg  = quad[1];
        u2   = (u * u) >> 16;
        poly = 64'd42048 - ((u2 * 64'd4640) >> 16);
        poly = 64'd102944 - ((u2 * poly) >> 16);
        s    = (u * poly) >> 16;
        return (s * 32767 + 32768) >> 16;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] mix_and_advance();
        longint sum;
        longint term;
        longint unsigned mag;
        longint unsigned step;
        logic neg;
        sum = 0;
        for (int v = 0; v < VOICES; v++)
        begin
            mag  = sine_q15(phase_now[v], neg);
            term = longint'((longint'(level_now[v]) * mag) >> 15);
            sum  = neg ? sum - term : sum + term;
        end
        for (int v = 0; v < VOICES; v++)
        begin
            step = (PITCH_STEP[v % 12] << (v / 12)) >> (32 - PHASE_BITS);
            phase_now[v] = PHASE_BITS'(longint'(phase_now[v]) + step);
            level_now[v] = LEVEL_W'((longint'(level_now[v]) * decay_now) >> 16);
        end
        if (sum > 64'sd2147483647)
        begin
            saturated_count++;
            sum = 64'sd2147483647;
        end
        else if (sum < -64'sd2147483648)
        begin
            saturated_count++;
            sum = -64'sd2147483648;
        end
        return SAMPLE_W'(sum);
    endfunction

    task automatic send_item(input op_t kind, input logic [NOTE_W-1:0] note);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= kind;
        note_index <= note;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
        if (kind == OP_KEY)
        begin
            if (note < VOICES)
                level_now[note] = peak_now;
        end
        else
            samples_due.push_back(mix_and_advance());
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == PEAK_ADDR)
            peak_now = data[LEVEL_W-1:0];
        else
            decay_now = data[DECAY_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (samples_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] peak, input logic [31:0] decay);
        drain();
        write_reg(PEAK_ADDR, peak);
        write_reg(DECAY_ADDR, decay);
    endtask

    task automatic test_silence();
        send_item(OP_TICK, 4'd0);
        send_item(OP_KEY, 4'd13);
        send_item(OP_KEY, 4'd14);
        send_item(OP_KEY, 4'd15);
        send_item(OP_TICK, 4'd15);
        send_item(OP_TICK, 4'd7);
    endtask

    // lowest and highest voice, then a restrike while the first is fading
    task automatic test_single_voices();
        send_item(OP_KEY, 4'd0);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd9);
        send_item(OP_KEY, 4'd12);
        send_item(OP_TICK, 4'd3);
        send_item(OP_KEY, 4'd0);
        send_item(OP_TICK, 4'd0);
    endtask

    task automatic test_register_extremes();
        set_config(32'hFFFF_FFFF, 32'h0000_FFFF);
        for (int v = 0; v < VOICES; v += 3)
            send_item(OP_KEY, NOTE_W'(v));
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        set_config(32'h0000_0000, 32'h0000_0000);
        send_item(OP_KEY, 4'd5);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
    endtask

    task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
        logic [NOTE_W-1:0] note;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                if ($urandom_range(4) == 0)
                    note = NOTE_W'($urandom_range(15, VOICES));
                else
                    note = NOTE_W'($urandom_range(VOICES - 1, 0));
                send_item(OP_KEY, note);
            end
            else
                send_item(OP_TICK, NOTE_W'($urandom_range(15)));
        end
    endtask

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // result side: random back-pressure and comparison with the oldest prediction
    initial
    begin
        logic signed [SAMPLE_W-1:0] want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                sample_count++;
                if (samples_due.size() == 0)
                begin
                    $error("sample_out transaction with nothing expected: got %0d", sample_out);
                    fail_count++;
                end
                else
                begin
                    want = samples_due.pop_front();
                    if (sample_out !== want)
                    begin
                        $error("sample_out mismatch: expected %0d, actual %0d", want, sample_out);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        op             = 1'b0;
        note_index     = '0;
        fail_count     = 0;
        sent_count     = 0;
        sample_count   = 0;
        saturated_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        peak_now       = PEAK_RESET;
        decay_now      = DECAY_RESET;
        for (int v = 0; v < VOICES; v++)
        begin
            level_now[v] = '0;
            phase_now[v] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_silence();
        test_single_voices();
        test_register_extremes();

        set_config(32'd165191049, 32'd65529);
        test_random_mix(230, 0, 0);
        set_config(32'h7FFF_FFFF, 32'd65535);
        test_random_mix(230, 52, 0);
        set_config($urandom, 32'(65536 - $urandom_range(400, 1)) | ($urandom & 32'hFFFF_0000));
        test_random_mix(230, 0, 52);
        set_config($urandom_range(32'h7FFF_FFFF), $urandom);
        test_random_mix(230, 14, 14);

        drain();
        $display("%0d transactions sent, %0d samples checked, %0d of them saturated",
                 sent_count, sample_count, saturated_count);
        $display("covered silent and out-of-range keys, restrikes, register extremes, idle mixes");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: polyphonic_decay_tone_synth.f
hdl/pdts_pkg.sv
hdl/pdts_regs.sv
hdl/pdts_dp.sv
hdl/pdts_ctrl.sv
hdl/polyphonic_decay_tone_synth.sv
bench/polyphonic_decay_tone_synth_tb.sv
